// ----- rtl/y86d_pkg.sv -----
// y86d_pkg: shared types, constants and the opcode classifier of the y86 decoder.
// Used by y86d_front, y86d_queue, y86d_back and y86_instruction_decoder.
`default_nettype none

package y86d_pkg;

    // width of the stream offset counter
    localparam int OFFSET_BITS = 16;

    // decode status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    // dense mnemonic codes (group bases)
    localparam logic [4:0] MN_NOP    = 5'd0;
    localparam logic [4:0] MN_HALT   = 5'd1;
    localparam logic [4:0] MN_RRMOVL = 5'd2;
    localparam logic [4:0] MN_ADDL   = 5'd6;
    localparam logic [4:0] MN_JMP    = 5'd12;
    localparam logic [4:0] MN_CALL   = 5'd19;
    localparam logic [4:0] MN_RET    = 5'd20;
    localparam logic [4:0] MN_PUSHL  = 5'd21;
    localparam logic [4:0] MN_POPL   = 5'd22;
    localparam logic [4:0] MN_READB  = 5'd23;
    localparam logic [4:0] MN_WRITEB = 5'd25;
    localparam logic [4:0] MN_MOVSBL = 5'd27;

    // opcode high nibbles
    localparam logic [3:0] OP_NOP    = 4'h0;
    localparam logic [3:0] OP_HALT   = 4'h1;
    localparam logic [3:0] OP_RRMOVL = 4'h2;
    localparam logic [3:0] OP_IRMOVL = 4'h3;
    localparam logic [3:0] OP_RMMOVL = 4'h4;
    localparam logic [3:0] OP_MRMOVL = 4'h5;
    localparam logic [3:0] OP_ALU    = 4'h6;
    localparam logic [3:0] OP_JXX    = 4'h7;
    localparam logic [3:0] OP_CALL   = 4'h8;
    localparam logic [3:0] OP_RET    = 4'h9;
    localparam logic [3:0] OP_PUSHL  = 4'ha;
    localparam logic [3:0] OP_POPL   = 4'hb;
    localparam logic [3:0] OP_READ   = 4'hc;
    localparam logic [3:0] OP_WRITE  = 4'hd;
    localparam logic [3:0] OP_MOVSBL = 4'he;

    // highest function nibble per group
    localparam logic [3:0] ALU_FN_MAX = 4'd5;
    localparam logic [3:0] JXX_FN_MAX = 4'd6;
    localparam logic [3:0] RW_FN_MAX  = 4'd1;

    // instruction lengths
    localparam logic [2:0] LEN_1 = 3'd1;
    localparam logic [2:0] LEN_2 = 3'd2;
    localparam logic [2:0] LEN_5 = 3'd5;
    localparam logic [2:0] LEN_6 = 3'd6;

    // opcode class, as seen by the front end
    typedef struct packed {
        logic       valid;
        logic [4:0] code;
        logic [2:0] len;
        logic       has_reg;
    } t_cls;

    // one byte beat travelling from front to back
    typedef struct packed {
        logic [7:0]             code_byte;
        logic                   last;
        logic [OFFSET_BITS-1:0] offset;
        t_cls                   cls;
    } t_item;

    // one decoded instruction
    typedef struct packed {
        logic [4:0]             mnemonic;
        logic [3:0]             reg_a;
        logic [3:0]             reg_b;
        logic [31:0]            immediate;
        logic [2:0]             instr_length;
        logic [OFFSET_BITS-1:0] instr_offset;
        logic [1:0]             decode_status;
    } t_result;

    // classify a byte as if it were an opcode
    function automatic t_cls classify(input logic [7:0] op);
        logic [3:0] hi;
        logic [3:0] lo;
        t_cls       c;
        hi = op[7:4];
        lo = op[3:0];
        c.valid   = 1'b0;
        c.code    = MN_NOP;
        c.len     = LEN_1;
        c.has_reg = 1'b0;
        unique case (hi)
            OP_NOP: begin
                c.valid = (lo == 4'd0);
            end
            OP_HALT: begin
                c.valid = (lo == 4'd0);
                c.code  = MN_HALT;
            end
            OP_RRMOVL: begin
                c.valid   = (lo == 4'd0);
                c.code    = MN_RRMOVL;
                c.len     = LEN_2;
                c.has_reg = 1'b1;
            end
            OP_IRMOVL, OP_RMMOVL, OP_MRMOVL: begin
                // mnemonic equals the high nibble for this group
                c.valid   = (lo == 4'd0);
                c.code    = {1'b0, hi};
                c.len     = LEN_6;
                c.has_reg = 1'b1;
            end
            OP_ALU: begin
                c.valid   = (lo <= ALU_FN_MAX);
                c.code    = MN_ADDL + {1'b0, lo};
                c.len     = LEN_2;
                c.has_reg = 1'b1;
            end
            OP_JXX: begin
                c.valid = (lo <= JXX_FN_MAX);
                c.code  = MN_JMP + {1'b0, lo};
                c.len   = LEN_5;
            end
            OP_CALL: begin
                c.valid = (lo == 4'd0);
                c.code  = MN_CALL;
                c.len   = LEN_5;
            end
            OP_RET: begin
                c.valid = (lo == 4'd0);
                c.code  = MN_RET;
            end
            OP_PUSHL: begin
                c.valid   = (lo == 4'd0);
                c.code    = MN_PUSHL;
                c.len     = LEN_2;
                c.has_reg = 1'b1;
            end
            OP_POPL: begin
                c.valid   = (lo == 4'd0);
                c.code    = MN_POPL;
                c.len     = LEN_2;
                c.has_reg = 1'b1;
            end
            OP_READ: begin
                c.valid   = (lo <= RW_FN_MAX);
                c.code    = MN_READB + {1'b0, lo};
                c.len     = LEN_6;
                c.has_reg = 1'b1;
            end
            OP_WRITE: begin
                c.valid   = (lo <= RW_FN_MAX);
                c.code    = MN_WRITEB + {1'b0, lo};
                c.len     = LEN_6;
                c.has_reg = 1'b1;
            end
            OP_MOVSBL: begin
                c.valid   = (lo == 4'd0);
                c.code    = MN_MOVSBL;
                c.len     = LEN_6;
                c.has_reg = 1'b1;
            end
            default: begin
                c.valid = 1'b0;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/y86d_front.sv -----
// y86d_front: accepts code byte beats, tags each with its stream offset and
// opcode class. Depends on y86d_pkg.
`default_nettype none

module y86d_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire logic            i_full,
    input  wire logic [7:0]      i_code_byte,
    input  wire logic            i_final_byte,
    output logic                 o_push,
    output y86d_pkg::t_item      o_item
);

    logic [y86d_pkg::OFFSET_BITS-1:0] r_offset;
    logic [y86d_pkg::OFFSET_BITS-1:0] n_offset;

    // beat accepted when the queue has room
    assign o_push = i_push && !i_full;

    always_comb begin
        o_item.code_byte = i_code_byte;
        o_item.last      = i_final_byte;
        o_item.offset    = r_offset;
        o_item.cls       = y86d_pkg::classify(i_code_byte);
    end

    // offset of the next byte; restarts after the last byte of a stream
    always_comb begin
        n_offset = r_offset;
        if (o_push) begin
            if (i_final_byte) begin
                n_offset = '0;
            end else begin
                n_offset = r_offset + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else begin
            r_offset <= n_offset;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/y86d_queue.sv -----
// y86d_queue: two-entry queue of tagged byte beats between front and back.
// Depends on y86d_pkg.
`default_nettype none

module y86d_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire y86d_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output y86d_pkg::t_item      o_item
);

    y86d_pkg::t_item r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;
    logic            push_ok;
    logic            pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/y86d_back.sv -----
// y86d_back: assembles instructions from tagged byte beats and holds finished
// results in a two-entry output queue. Depends on y86d_pkg.
`default_nettype none

module y86d_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    output logic                 o_pop,
    input  wire y86d_pkg::t_item i_item,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output y86d_pkg::t_result    o_res
);

    // instruction assembly state
    logic [2:0]                       r_taken;
    logic [4:0]                       r_code;
    logic [2:0]                       r_len;
    logic                             r_has_reg;
    logic [7:0]                       r_regs;
    logic [31:0]                      r_imm;
    logic [y86d_pkg::OFFSET_BITS-1:0] r_start;
    logic [2:0]                       n_taken;
    logic [4:0]                       n_code;
    logic [2:0]                       n_len;
    logic                             n_has_reg;
    logic [7:0]                       n_regs;
    logic [31:0]                      n_imm;
    logic [y86d_pkg::OFFSET_BITS-1:0] n_start;

    // output queue
    y86d_pkg::t_result r_oq [2];
    logic              r_owp;
    logic              r_orp;
    logic [1:0]        r_ocnt;
    logic [1:0]        n_ocnt;
    logic              out_pop_ok;

    logic              fire;
    logic              emit;
    y86d_pkg::t_result res;
    logic [2:0]        taken_inc;
    logic [2:0]        imm_idx;
    logic [4:0]        imm_sh;

    // consume a beat when the output queue can take a result
    assign fire  = !i_empty && (r_ocnt != 2'd2);
    assign o_pop = fire;

    always_comb begin
        n_taken   = r_taken;
        n_code    = r_code;
        n_len     = r_len;
        n_has_reg = r_has_reg;
        n_regs    = r_regs;
        n_imm     = r_imm;
        n_start   = r_start;
        emit      = 1'b0;
        res       = '0;
        taken_inc = r_taken + 3'd1;
        imm_idx   = r_taken - (r_has_reg ? 3'd2 : 3'd1);
        imm_sh    = {imm_idx[1:0], 3'b000};
        if (fire) begin
            if (r_taken == 3'd0) begin
                // opcode byte
                n_start   = i_item.offset;
                n_code    = i_item.cls.code;
                n_len     = i_item.cls.len;
                n_has_reg = i_item.cls.has_reg;
                n_regs    = 8'd0;
                n_imm     = 32'd0;
                if (!i_item.cls.valid) begin
                    emit              = 1'b1;
                    res.mnemonic      = y86d_pkg::MN_NOP;
                    res.instr_length  = y86d_pkg::LEN_1;
                    res.instr_offset  = i_item.offset;
                    res.decode_status = y86d_pkg::ST_INVALID;
                end else if (i_item.cls.len == y86d_pkg::LEN_1) begin
                    emit              = 1'b1;
                    res.mnemonic      = i_item.cls.code;
                    res.instr_length  = y86d_pkg::LEN_1;
                    res.instr_offset  = i_item.offset;
                    res.decode_status = y86d_pkg::ST_OK;
                end else begin
                    n_taken = 3'd1;
                end
            end else begin
                // register byte or one immediate byte
                if (r_has_reg && (r_taken == 3'd1)) begin
                    n_regs = i_item.code_byte;
                end else begin
                    n_imm = r_imm | (32'(i_item.code_byte) << imm_sh);
                end
                if (taken_inc >= r_len) begin
                    emit              = 1'b1;
                    res.mnemonic      = r_code;
                    res.reg_a         = r_has_reg ? n_regs[7:4] : 4'd0;
                    res.reg_b         = r_has_reg ? n_regs[3:0] : 4'd0;
                    res.immediate     = n_imm;
                    res.instr_length  = r_len;
                    res.instr_offset  = r_start;
                    res.decode_status = y86d_pkg::ST_OK;
                    n_taken           = 3'd0;
                end else begin
                    n_taken = taken_inc;
                end
            end
            // end of stream: flush a partial instruction
            if (i_item.last) begin
                if (!emit && (n_taken != 3'd0)) begin
                    emit              = 1'b1;
                    res.mnemonic      = n_code;
                    res.reg_a         = (n_has_reg && n_taken >= 3'd2) ? n_regs[7:4] : 4'd0;
                    res.reg_b         = (n_has_reg && n_taken >= 3'd2) ? n_regs[3:0] : 4'd0;
                    res.immediate     = n_imm;
                    res.instr_length  = n_taken;
                    res.instr_offset  = n_start;
                    res.decode_status = y86d_pkg::ST_TRUNC;
                end
                n_taken = 3'd0;
            end
        end
    end

    // assembly control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= 3'd0;
        end else begin
            r_taken <= n_taken;
        end
    end

    // assembly payload
    always_ff @(posedge i_clk) begin
        r_code    <= n_code;
        r_len     <= n_len;
        r_has_reg <= n_has_reg;
        r_regs    <= n_regs;
        r_imm     <= n_imm;
        r_start   <= n_start;
    end

    // output queue
    assign o_empty    = (r_ocnt == 2'd0);
    assign o_res      = r_oq[r_orp];
    assign out_pop_ok = i_pop && !o_empty;

    always_comb begin
        n_ocnt = r_ocnt + {1'b0, emit} - {1'b0, out_pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (emit) begin
                r_owp <= ~r_owp;
            end
            if (out_pop_ok) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= n_ocnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_oq[r_owp] <= res;
        end
    end

`ifndef SYNTHESIS
    // output queue never overfills
    a_ocnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt != 2'd3)
        else $error("output queue count out of range");

    // a held instruction is always short of its full length
    a_taken_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_taken != 3'd0) |-> (r_taken < r_len))
        else $error("partial instruction reached its length");

    // the last byte of a stream leaves nothing pending
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_item.last) |=> (r_taken == 3'd0))
        else $error("instruction still pending after end of stream");
`endif

endmodule

`default_nettype wire

// ----- rtl/y86_instruction_decoder.sv -----
// y86_instruction_decoder: top level of the y86 code byte decoder.
// Instantiates y86d_front, y86d_queue and y86d_back; depends on y86d_pkg.
//
// Usage:
//   Input channel: one code byte per beat with a final-byte flag, taken at a
//   clock edge where push is high and full is low. Bytes of one stream get
//   offsets 0, 1, 2, ...; a byte flagged final ends the stream and the next
//   byte starts a new one at offset 0.
//   Result channel: one decoded instruction per beat (mnemonic, register
//   nibbles, immediate, length, start offset, status), shown while empty is
//   low and taken at an edge where pop is high.
//   Path: the byte that completes an instruction is registered in the front
//   queue, then its result is registered in the back end's output queue.
//   Throughput: one byte per cycle sustained while pop keeps the output queue
//   from filling; the back end consumes one beat a cycle from the two-entry
//   queue and writes at most one result a cycle into a two-entry output queue.
//   Stalls: if pop stays low, the output queue fills, the back end stops, the
//   front queue fills and full rises; no beat is lost or repeated.
//   Reset (synchronous, active low): both queues empty, offset counter zero,
//   decoder waits for an opcode byte.
`default_nettype none

module y86_instruction_decoder (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [7:0]                       i_code_byte,
    input  wire logic                             i_final_byte,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [4:0]                            o_mnemonic,
    output logic [3:0]                            o_reg_a,
    output logic [3:0]                            o_reg_b,
    output logic [31:0]                           o_immediate,
    output logic [2:0]                            o_instr_length,
    output logic [y86d_pkg::OFFSET_BITS-1:0]      o_instr_offset,
    output logic [1:0]                            o_decode_status
);

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    y86d_pkg::t_item   front_item;
    y86d_pkg::t_item   q_item;
    y86d_pkg::t_result res;

    // front end: offset tagging and opcode classification
    y86d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (q_full),
        .i_code_byte  (i_code_byte),
        .i_final_byte (i_final_byte),
        .o_push       (q_push),
        .o_item       (front_item)
    );

    // decoupling queue
    y86d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    // back end: instruction assembly and result queue
    y86d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .i_item  (q_item),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (res)
    );

    assign full            = q_full;
    assign o_mnemonic      = res.mnemonic;
    assign o_reg_a         = res.reg_a;
    assign o_reg_b         = res.reg_b;
    assign o_immediate     = res.immediate;
    assign o_instr_length  = res.instr_length;
    assign o_instr_offset  = res.instr_offset;
    assign o_decode_status = res.decode_status;

endmodule

`default_nettype wire
